@@ hdl/pbc_pkg.sv @@
// shared constants, mode codes and table functions for the pixel blend compositor
package pbc_pkg;

	localparam logic [16:0] Q_ONE   = 17'h10000;
	localparam logic [16:0] Q_HALF  = 17'h08000;
	localparam logic [16:0] Q_QUART = 17'h04000;

	localparam logic [3:0] BM_NORMAL   = 4'd0;
	localparam logic [3:0] BM_ADD      = 4'd1;
	localparam logic [3:0] BM_DARKEST  = 4'd2;
	localparam logic [3:0] BM_LIGHTEST = 4'd3;
	localparam logic [3:0] BM_DIFF     = 4'd4;
	localparam logic [3:0] BM_EXCL     = 4'd5;
	localparam logic [3:0] BM_MULTIPLY = 4'd6;
	localparam logic [3:0] BM_SCREEN   = 4'd7;
	localparam logic [3:0] BM_OVERLAY  = 4'd8;
	localparam logic [3:0] BM_HARD     = 4'd9;
	localparam logic [3:0] BM_SOFT     = 4'd10;
	localparam logic [3:0] BM_DODGE    = 4'd11;
	localparam logic [3:0] BM_BURN     = 4'd12;
	localparam logic [3:0] BM_REPLACE  = 4'd13;
	localparam logic [3:0] BM_REMOVE   = 4'd14;

	localparam logic REG_BLEND_MODE = 1'b0;

	function automatic logic [16:0] to_q16(input logic [7:0] b);
		return {1'b0, b, b} + 17'(b[7]);
	endfunction

	function automatic logic [30:0] soft_g(input logic [7:0] b);
		logic [63:0] d;
		logic [63:0] t;
		d = 64'(to_q16(b));
		t = d * (64'(Q_ONE) - d);
		return t[30:0];
	endfunction

	function automatic logic [16:0] soft_h(input logic [7:0] b);
		logic [63:0] d;
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] bt;
		logic [63:0] h;
		logic [63:0] pos;
		logic [63:0] neg;
		d = 64'(to_q16(b));
		if (d <= 64'(Q_QUART)) begin
			pos = 64'd16 * d * d * d + ((64'd4 * d) << 32);
			neg = (64'd12 * d * d) << 16;
			h = (pos - neg + 64'h8000_0000) >> 32;
		end else begin
			x = d << 16;
			r = '0;
			bt = 64'd1 << 32;
			for (int i = 0; i < 17; i++) begin
				if (x >= r + bt) begin
					x = x - (r + bt);
					r = (r >> 1) + bt;
				end else begin
					r = r >> 1;
				end
				bt = bt >> 2;
			end
			if (x > r) begin
				r = r + 64'd1;
			end
			h = r;
		end
		if (h < d) begin
			h = d;
		end
		return h[16:0];
	endfunction

endpackage

@@ hdl/pbc_if.sv @@
// valid/ready channel interfaces for pixel pairs and composited pixels
interface pbc_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] dst_alpha;
	logic [7:0] dst_red;
	logic [7:0] dst_green;
	logic [7:0] dst_blue;
	logic [7:0] src_alpha;
	logic [7:0] src_red;
	logic [7:0] src_green;
	logic [7:0] src_blue;

	modport source(output valid, dst_alpha, dst_red, dst_green, dst_blue,
		src_alpha, src_red, src_green, src_blue, input ready);
	modport sink(input valid, dst_alpha, dst_red, dst_green, dst_blue,
		src_alpha, src_red, src_green, src_blue, output ready);
endinterface

interface pbc_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_alpha;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;

	modport source(output valid, out_alpha, out_red, out_green, out_blue, input ready);
	modport sink(input valid, out_alpha, out_red, out_green, out_blue, output ready);
endinterface

@@ hdl/pbc_delay.sv @@
// enabled shift line that keeps side data aligned with the pipeline
module pbc_delay #(
	parameter int W = 8,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] sr_q [D];

	always_ff @(posedge clk) begin
		if (en) begin
			sr_q[0] <= din;
			for (int k = 1; k < D; k++) begin
				sr_q[k] <= sr_q[k-1];
			end
		end
	end

	assign dout = sr_q[D-1];

endmodule

@@ hdl/pbc_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module pbc_div #(
	parameter int DW = 29,
	parameter int VW = 17,
	parameter int QW = 8
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] num,
	input  logic [VW-1:0] den,
	output logic [QW-1:0] quo
);

	localparam int CW = (DW > VW + QW) ? DW : VW + QW;

	logic [CW-1:0] rem_q [QW-1];
	logic [VW-1:0] den_q [QW-1];
	logic [QW-1:0] quo_q [QW];

	for (genvar k = 0; k < QW; k++) begin : g_st
		logic [CW-1:0] r_in;
		logic [CW-1:0] t;
		logic [VW-1:0] d_in;
		logic [QW-1:0] q_in;
		logic [QW-1:0] q_nx;
		logic          ge;

		if (k == 0) begin : g_first
			assign r_in = CW'(num);
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_q[k-1];
			assign d_in = den_q[k-1];
			assign q_in = quo_q[k-1];
		end

		assign t  = CW'(d_in) << (QW - 1 - k);
		assign ge = (r_in >= t);

		always_comb begin
			q_nx = q_in;
			q_nx[QW-1-k] = ge;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_q[k] <= q_nx;
			end
		end

		if (k < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k] <= ge ? r_in - t : r_in;
					den_q[k] <= d_in;
				end
			end
		end
	end

	assign quo = quo_q[QW-1];

endmodule

@@ hdl/pbc_blend.sv @@
// per-channel blend result, multiply path and saturating divide path
module pbc_blend (
	input  logic        clk,
	input  logic        en,
	input  logic [3:0]  mode,
	input  logic [16:0] d,
	input  logic [16:0] s,
	input  logic [30:0] g,
	input  logic [16:0] h,
	output logic [16:0] bc
);

	localparam int DIV_QW = 17;

	function automatic logic [16:0] sat17(input logic [33:0] v);
		return (v > 34'(pbc_pkg::Q_ONE)) ? pbc_pkg::Q_ONE : v[16:0];
	endfunction

	logic [17:0] s2x;
	logic        lo;
	logic [16:0] op_a;
	logic [30:0] op_b;
	logic [16:0] den_d;
	logic [16:0] one_d;
	logic [32:0] dv_num;
	logic [16:0] dv_den;
	logic        dv_sp;
	logic        dv_ov;

	logic [47:0] m_b1;
	logic [16:0] d_b1;
	logic [16:0] s_b1;
	logic        lo_b1;
	logic [32:0] num_b1;
	logic [16:0] den_b1;
	logic        sat_b1;

	assign s2x   = {s, 1'b0};
	assign den_d = pbc_pkg::Q_ONE - s;
	assign one_d = pbc_pkg::Q_ONE - d;

	always_comb begin
		case (mode) inside
			pbc_pkg::BM_OVERLAY: lo = (d <= pbc_pkg::Q_HALF);
			default:             lo = (s <= pbc_pkg::Q_HALF);
		endcase
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (mode) inside
			pbc_pkg::BM_EXCL, pbc_pkg::BM_MULTIPLY: begin
				op_a = d;
				op_b = 31'(s);
			end
			pbc_pkg::BM_SCREEN: begin
				op_a = one_d;
				op_b = 31'(den_d);
			end
			pbc_pkg::BM_OVERLAY, pbc_pkg::BM_HARD: begin
				op_a = lo ? d : one_d;
				op_b = lo ? 31'(s) : 31'(den_d);
			end
			pbc_pkg::BM_SOFT: begin
				op_a = lo ? 17'(18'(pbc_pkg::Q_ONE) - s2x) : 17'(s2x - 18'(pbc_pkg::Q_ONE));
				op_b = lo ? g : 31'(h - d);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_comb begin
		if (mode == pbc_pkg::BM_BURN) begin
			dv_num = {one_d, 16'b0} + 33'(s >> 1);
			dv_den = s;
			dv_sp  = (s == '0);
		end else begin
			dv_num = {d, 16'b0} + 33'(den_d >> 1);
			dv_den = den_d;
			dv_sp  = (s == pbc_pkg::Q_ONE);
		end
		dv_ov = (17'(dv_num[32:17]) >= dv_den);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_b1   <= 48'(op_a) * 48'(op_b);
			d_b1   <= d;
			s_b1   <= s;
			lo_b1  <= lo;
			num_b1 <= dv_num;
			den_b1 <= dv_den;
			sat_b1 <= dv_sp | dv_ov;
		end
	end

	logic [48:0] m1r;
	logic [48:0] m2r;
	logic [49:0] ex;
	logic [49:0] sl;
	logic [33:0] sh;
	logic [16:0] r;
	logic        sel;

	assign m1r = 49'(m_b1) + 49'(pbc_pkg::Q_HALF);
	assign m2r = (49'(m_b1) << 1) + 49'(pbc_pkg::Q_HALF);
	assign ex  = (50'(18'(d_b1) + 18'(s_b1)) << 16) - (50'(m_b1) << 1)
		+ 50'(pbc_pkg::Q_HALF);
	assign sl  = (50'(d_b1) << 32) - 50'(m_b1) + 50'h8000_0000;
	assign sh  = 34'(d_b1) + 34'(m1r[48:16]);

	always_comb begin
		case (mode) inside
			pbc_pkg::BM_ADD:      r = sat17(34'(d_b1) + 34'(s_b1));
			pbc_pkg::BM_DARKEST:  r = (d_b1 < s_b1) ? d_b1 : s_b1;
			pbc_pkg::BM_LIGHTEST: r = (d_b1 > s_b1) ? d_b1 : s_b1;
			pbc_pkg::BM_DIFF:     r = (d_b1 > s_b1) ? d_b1 - s_b1 : s_b1 - d_b1;
			pbc_pkg::BM_EXCL:     r = ex[32:16];
			pbc_pkg::BM_MULTIPLY: r = m1r[32:16];
			pbc_pkg::BM_SCREEN:   r = pbc_pkg::Q_ONE - m1r[32:16];
			pbc_pkg::BM_OVERLAY, pbc_pkg::BM_HARD:
				r = lo_b1 ? sat17(m2r[48:15] >> 1) : pbc_pkg::Q_ONE - m2r[32:16];
			pbc_pkg::BM_SOFT:     r = lo_b1 ? sl[48:32] : sat17(sh);
			pbc_pkg::BM_DODGE:    r = pbc_pkg::Q_ONE;
			pbc_pkg::BM_BURN:     r = '0;
			default:              r = s_b1;
		endcase
	end

	assign sel = ((mode == pbc_pkg::BM_DODGE) || (mode == pbc_pkg::BM_BURN)) && !sat_b1;

	logic [16:0] r_b2;
	logic        sel_b2;
	logic [16:0] r_dly;
	logic        sel_dly;
	logic [16:0] q;
	logic [16:0] qs;

	always_ff @(posedge clk) begin
		if (en) begin
			r_b2   <= r;
			sel_b2 <= sel;
		end
	end

	// line up the direct result with the divider output
	pbc_delay #(.W(18), .D(DIV_QW - 1)) u_align (
		.clk  (clk),
		.en   (en),
		.din  ({sel_b2, r_b2}),
		.dout ({sel_dly, r_dly})
	);

	pbc_div #(.DW(33), .VW(17), .QW(DIV_QW)) u_div (
		.clk (clk),
		.en  (en),
		.num (num_b1),
		.den (den_b1),
		.quo (q)
	);

	assign qs = sat17(34'(q));

	always_ff @(posedge clk) begin
		if (en) begin
			if (sel_dly) begin
				bc <= (mode == pbc_pkg::BM_BURN) ? pbc_pkg::Q_ONE - qs : qs;
			end else begin
				bc <= r_dly;
			end
		end
	end

endmodule

@@ hdl/pixel_blend_compositor_unit.sv @@
// top level: source-over compositing with separable blend modes
// throughput: one word per cycle; a held output word stalls every stage at once
// the depth is set by the 17-stage blend divider and the 8-stage output divider
// reset clears all stage valid bits and sets the blend mode to normal
module pixel_blend_compositor_unit (
	input  logic             clk,
	input  logic             arst_n,
	pbc_pix_if.sink          pix_in,
	pbc_res_if.source        pix_out,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int NST = 34;

	logic           adv;
	logic [NST-1:0] vld_q;
	logic [3:0]     mode_q;

	assign adv          = !vld_q[NST-1] || pix_out.ready;
	assign pix_in.ready = adv;
	assign pix_out.valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], pix_in.valid};
		end
	end

	// config register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pbc_pkg::BM_NORMAL;
		end else if (psel && penable && pwrite && (paddr[2] == pbc_pkg::REG_BLEND_MODE)) begin
			mode_q <= pwdata[3:0];
		end
	end

	assign prdata = (paddr[2] == pbc_pkg::REG_BLEND_MODE) ? 32'(mode_q) : '0;

	// soft light helper tables indexed by destination byte
	logic [16:0] h_tab [256];
	logic [30:0] g_tab [256];

	for (genvar i = 0; i < 256; i++) begin : g_tab_fill
		assign h_tab[i] = pbc_pkg::soft_h(8'(i));
		assign g_tab[i] = pbc_pkg::soft_g(8'(i));
	end

	// stage 1: input word
	logic [7:0] dst_s1 [4];
	logic [7:0] src_s1 [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			dst_s1[0] <= pix_in.dst_alpha;
			dst_s1[1] <= pix_in.dst_red;
			dst_s1[2] <= pix_in.dst_green;
			dst_s1[3] <= pix_in.dst_blue;
			src_s1[0] <= pix_in.src_alpha;
			src_s1[1] <= pix_in.src_red;
			src_s1[2] <= pix_in.src_green;
			src_s1[3] <= pix_in.src_blue;
		end
	end

	// stage 2: fixed point conversion and table reads
	logic [16:0] sa_s2;
	logic [16:0] da_s2;
	logic [16:0] dc_s2 [3];
	logic [16:0] sc_s2 [3];
	logic [30:0] g_s2 [3];
	logic [16:0] h_s2 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			sa_s2 <= pbc_pkg::to_q16(src_s1[0]);
			da_s2 <= pbc_pkg::to_q16(dst_s1[0]);
			for (int c = 0; c < 3; c++) begin
				dc_s2[c] <= pbc_pkg::to_q16(dst_s1[c+1]);
				sc_s2[c] <= pbc_pkg::to_q16(src_s1[c+1]);
				g_s2[c]  <= g_tab[dst_s1[c+1]];
				h_s2[c]  <= h_tab[dst_s1[c+1]];
			end
		end
	end

	// stages 3 to 5: alpha weights and output alpha
	logic [32:0] wa_s3;
	logic [32:0] wb_s3;
	logic [32:0] wc_s3;
	logic [16:0] sa_s3;
	logic [33:0] wa_r;
	logic [17:0] oa_sum;
	logic [16:0] oa_s4;
	logic [24:0] oa_x;
	logic [7:0]  alpha_s5;
	logic        transp_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			wa_s3 <= 33'(34'(pbc_pkg::Q_ONE - sa_s2) * 34'(da_s2));
			wb_s3 <= 33'(34'(pbc_pkg::Q_ONE - da_s2) * 34'(sa_s2));
			wc_s3 <= 33'(34'(da_s2) * 34'(sa_s2));
			sa_s3 <= sa_s2;
		end
	end

	assign wa_r   = 34'(wa_s3) + 34'(pbc_pkg::Q_HALF);
	assign oa_sum = 18'(sa_s3) + wa_r[33:16];

	always_ff @(posedge clk) begin
		if (adv) begin
			oa_s4 <= oa_sum[16:0];
		end
	end

	assign oa_x = 25'(oa_s4) * 25'd255 + 25'(pbc_pkg::Q_HALF);

	always_ff @(posedge clk) begin
		if (adv) begin
			alpha_s5  <= (oa_x[24:16] > 9'd255) ? 8'hFF : oa_x[23:16];
			transp_s5 <= (oa_s4 == '0);
		end
	end

	// alignment lines
	logic [32:0] wa_d;
	logic [32:0] wb_d;
	logic [32:0] wc_d;
	logic [16:0] oa_d;
	logic [7:0]  alpha_d;
	logic        transp_d;
	logic [31:0] src_d;

	pbc_delay #(.W(99), .D(18)) u_dly_w (
		.clk  (clk),
		.en   (adv),
		.din  ({wa_s3, wb_s3, wc_s3}),
		.dout ({wa_d, wb_d, wc_d})
	);

	pbc_delay #(.W(17), .D(19)) u_dly_oa (
		.clk  (clk),
		.en   (adv),
		.din  (oa_s4),
		.dout (oa_d)
	);

	pbc_delay #(.W(9), .D(28)) u_dly_side (
		.clk  (clk),
		.en   (adv),
		.din  ({alpha_s5, transp_s5}),
		.dout ({alpha_d, transp_d})
	);

	pbc_delay #(.W(32), .D(32)) u_dly_src (
		.clk  (clk),
		.en   (adv),
		.din  ({src_s1[0], src_s1[1], src_s1[2], src_s1[3]}),
		.dout (src_d)
	);

	// per channel blend and alignment
	logic [16:0] dc_d [3];
	logic [16:0] sc_d [3];
	logic [16:0] bc_s21 [3];
	logic [7:0]  q_s33 [3];
	logic [28:0] y_s25 [3];
	logic [2:0]  ov_s25;
	logic [2:0]  ov_d;
	logic [16:0] oa_s24;
	logic [16:0] oa_s25;

	for (genvar c = 0; c < 3; c++) begin : g_ch
		pbc_delay #(.W(34), .D(19)) u_dly_c (
			.clk  (clk),
			.en   (adv),
			.din  ({dc_s2[c], sc_s2[c]}),
			.dout ({dc_d[c], sc_d[c]})
		);

		pbc_blend u_blend (
			.clk  (clk),
			.en   (adv),
			.mode (mode_q),
			.d    (dc_s2[c]),
			.s    (sc_s2[c]),
			.g    (g_s2[c]),
			.h    (h_s2[c]),
			.bc   (bc_s21[c])
		);

		pbc_div #(.DW(29), .VW(17), .QW(8)) u_div (
			.clk (clk),
			.en  (adv),
			.num (y_s25[c]),
			.den (oa_s25),
			.quo (q_s33[c])
		);
	end

	pbc_delay #(.W(3), .D(8)) u_dly_ov (
		.clk  (clk),
		.en   (adv),
		.din  (ov_s25),
		.dout (ov_d)
	);

	// stages 22 to 25: weighted sum, scale and range check
	logic [49:0] pa_s22 [3];
	logic [49:0] pb_s22 [3];
	logic [49:0] pc_s22 [3];
	logic [51:0] sum_s23 [3];
	logic [60:0] x [3];
	logic [28:0] y_s24 [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			x[c] = (61'(sum_s23[c]) << 8) - 61'(sum_s23[c]) + (61'(oa_d) << 31);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				pa_s22[c]  <= 50'(wa_d) * 50'(dc_d[c]);
				pb_s22[c]  <= 50'(wb_d) * 50'(sc_d[c]);
				pc_s22[c]  <= 50'(wc_d) * 50'(bc_s21[c]);
				sum_s23[c] <= 52'(pa_s22[c]) + 52'(pb_s22[c]) + 52'(pc_s22[c]);
				y_s24[c]   <= x[c][60:32];
				y_s25[c]   <= y_s24[c];
				ov_s25[c]  <= (y_s24[c][28:8] >= 21'(oa_s24));
			end
			oa_s24 <= oa_d;
			oa_s25 <= oa_s24;
		end
	end

	// stage 34: output word
	logic [7:0] col [3];
	logic [7:0] out_s34 [4];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			col[c] = ov_d[2-c] ? 8'hFF : q_s33[c];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (mode_q == pbc_pkg::BM_REPLACE) begin
				out_s34[0] <= src_d[31:24];
				out_s34[1] <= src_d[23:16];
				out_s34[2] <= src_d[15:8];
				out_s34[3] <= src_d[7:0];
			end else if (transp_d) begin
				for (int k = 0; k < 4; k++) begin
					out_s34[k] <= '0;
				end
			end else begin
				out_s34[0] <= alpha_d;
				for (int c = 0; c < 3; c++) begin
					out_s34[c+1] <= col[c];
				end
			end
		end
	end

	assign pix_out.out_alpha = out_s34[0];
	assign pix_out.out_red   = out_s34[1];
	assign pix_out.out_green = out_s34[2];
	assign pix_out.out_blue  = out_s34[3];

endmodule

@@ hdl/pbc_chk.sv @@
// port level checker for the compositor, bound to the top level
module pbc_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_alpha,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue
);

	// a held result word keeps its data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({out_alpha, out_red, out_green, out_blue}))
		else $error("held result word changed");

	// the input side only stalls while a result word is refused
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	// a result word only leaves after it was taken
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result word dropped");

	// an input word is only refused while the output is also stalled
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

endmodule

bind pixel_blend_compositor_unit pbc_chk u_pbc_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_alpha (pix_out.out_alpha),
	.out_red   (pix_out.out_red),
	.out_green (pix_out.out_green),
	.out_blue  (pix_out.out_blue)
);

@@ bench/testbench.sv @@
// testbench for the pixel blend compositor: directed and random pixel pairs checked against a predictor
`timescale 1ns / 100ps

module testbench;

	typedef struct packed {
		logic [7:0] da, dr, dg, db, sa, sr, sg, sb;
	} pixel_pair_t;

	typedef struct packed {
		logic [7:0] a, r, g, b;
	} argb_t;

	typedef longint unsigned u64_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	pbc_pix_if pix_in();
	pbc_res_if pix_out();

	pixel_blend_compositor_unit dut (
		.clk(clk), .arst_n(arst_n), .pix_in(pix_in), .pix_out(pix_out),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	argb_t expected_pixels[$];
	logic [3:0] mode_shadow = pbc_pkg::BM_NORMAL;
	int fail_count = 0;
	int src_idle = 0;
	int sink_stall = 0;
	int quiet_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic u64_t byte_to_q16(input logic [7:0] b);
		return (u64_t'(b) * 65536 + 127) / 255;
	endfunction

	function automatic u64_t round16(input u64_t x);
		return (x + 64'd32768) >> 16;
	endfunction

	function automatic u64_t round32(input u64_t x);
		return (x + 64'h8000_0000) >> 32;
	endfunction

	function automatic u64_t clip_one(input u64_t v);
		return v > 64'd65536 ? 64'd65536 : v;
	endfunction

	function automatic u64_t isqrt_round(input u64_t x0);
		u64_t x, r, bt;
		x = x0;
		r = 0;
		bt = 64'd1 << 40;
		while (bt > x) bt = bt >> 2;
		while (bt != 0) begin
			if (x >= r + bt) begin
				x = x - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		if (x > r) r = r + 1;
		return r;
	endfunction

	function automatic u64_t blend_q16(input u64_t d, input u64_t s, input logic [3:0] m);
		u64_t one, half, h, p, pos, neg, den;
		one = 64'd65536;
		half = 64'd32768;
		case (m)
			pbc_pkg::BM_ADD: return clip_one(d + s);
			pbc_pkg::BM_DARKEST: return d < s ? d : s;
			pbc_pkg::BM_LIGHTEST: return d > s ? d : s;
			pbc_pkg::BM_DIFF: return d > s ? d - s : s - d;
			pbc_pkg::BM_EXCL: return round16(((d + s) << 16) - 2 * d * s);
			pbc_pkg::BM_MULTIPLY: return round16(d * s);
			pbc_pkg::BM_SCREEN: return one - round16((one - d) * (one - s));
			pbc_pkg::BM_OVERLAY: begin
				if (d <= half) return clip_one(round16(2 * d * s));
				return one - round16(2 * (one - d) * (one - s));
			end
			pbc_pkg::BM_HARD: begin
				if (s <= half) return clip_one(round16(2 * d * s));
				return one - round16(2 * (one - d) * (one - s));
			end
			pbc_pkg::BM_SOFT: begin
				if (s <= half) begin
					p = (one - 2 * s) * d * (one - d);
					return round32((d << 32) - p);
				end
				if (d <= one / 4) begin
					pos = 16 * d * d * d + ((4 * d) << 32);
					neg = (12 * d * d) << 16;
					h = round32(pos - neg);
				end else begin
					h = isqrt_round(d << 16);
				end
				if (h < d) h = d;
				return clip_one(d + round16((2 * s - one) * (h - d)));
			end
			pbc_pkg::BM_DODGE: begin
				if (s >= one) return one;
				den = one - s;
				return clip_one(((d << 16) + den / 2) / den);
			end
			pbc_pkg::BM_BURN: begin
				if (s == 0) return 0;
				return one - clip_one((((one - d) << 16) + s / 2) / s);
			end
			default: return s;
		endcase
	endfunction

	function automatic argb_t composite_pixel(input pixel_pair_t p, input logic [3:0] m);
		argb_t o;
		u64_t sa, da, oa, a, den, dc, sc, bc, num, v;
		logic [7:0] dch[3], sch[3];
		u64_t res[3];
		if (m == pbc_pkg::BM_REPLACE) begin
			o = '{p.sa, p.sr, p.sg, p.sb};
			return o;
		end
		sa = byte_to_q16(p.sa);
		da = byte_to_q16(p.da);
		oa = sa + round16(da * (64'd65536 - sa));
		if (oa == 0) return '0;
		a = (oa * 255 + 64'd32768) >> 16;
		o.a = a > 255 ? 8'd255 : a[7:0];
		den = oa << 32;
		dch = '{p.dr, p.dg, p.db};
		sch = '{p.sr, p.sg, p.sb};
		for (int i = 0; i < 3; i++) begin
			dc = byte_to_q16(dch[i]);
			sc = byte_to_q16(sch[i]);
			bc = blend_q16(dc, sc, m);
			num = (64'd65536 - sa) * da * dc + (64'd65536 - da) * sa * sc + da * sa * bc;
			v = (num * 255 + den / 2) / den;
			res[i] = v > 255 ? 64'd255 : v;
		end
		o.r = res[0][7:0];
		o.g = res[1][7:0];
		o.b = res[2][7:0];
		return o;
	endfunction

	// receiver with random stall and result check
	always @(posedge clk) begin
		argb_t want, got;
		pix_out.ready <= ($urandom_range(99) >= sink_stall);
		if (arst_n && pix_out.valid && pix_out.ready) begin
			got = '{pix_out.out_alpha, pix_out.out_red, pix_out.out_green, pix_out.out_blue};
			if (expected_pixels.size() == 0) begin
				$display("%0t unexpected word: actual %h", $time, got);
				fail_count++;
			end else begin
				want = expected_pixels.pop_front();
				if (want.a !== got.a) begin
					$display("%0t out_alpha: expected %0d actual %0d", $time, want.a, got.a);
					fail_count++;
				end
				if (want.r !== got.r) begin
					$display("%0t out_red: expected %0d actual %0d", $time, want.r, got.r);
					fail_count++;
				end
				if (want.g !== got.g) begin
					$display("%0t out_green: expected %0d actual %0d", $time, want.g, got.g);
					fail_count++;
				end
				if (want.b !== got.b) begin
					$display("%0t out_blue: expected %0d actual %0d", $time, want.b, got.b);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
				!(pix_in.valid || expected_pixels.size() != 0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 3000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_pixel(input pixel_pair_t p);
		while ($urandom_range(99) < src_idle) begin
			pix_in.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.dst_alpha <= p.da;
		pix_in.dst_red <= p.dr;
		pix_in.dst_green <= p.dg;
		pix_in.dst_blue <= p.db;
		pix_in.src_alpha <= p.sa;
		pix_in.src_red <= p.sr;
		pix_in.src_green <= p.sg;
		pix_in.src_blue <= p.sb;
		@(posedge clk);
		while (!pix_in.ready) @(posedge clk);
		expected_pixels.push_back(composite_pixel(p, mode_shadow));
	endtask

	task automatic drain;
		pix_in.valid <= 1'b0;
		@(posedge clk);
		while (expected_pixels.size() != 0) @(posedge clk);
	endtask

	task automatic write_mode(input logic [3:0] m);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 3'(4 * pbc_pkg::REG_BLEND_MODE);
		pwdata <= 32'(m);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		mode_shadow = m;
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_byte;
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'(127 + $urandom_range(2));
			3: return 8'($urandom_range(64));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic pixel_pair_t random_pair;
		pixel_pair_t p;
		p = '{pick_byte(), pick_byte(), pick_byte(), pick_byte(),
			pick_byte(), pick_byte(), pick_byte(), pick_byte()};
		return p;
	endfunction

	task automatic test_directed;
		logic [3:0] m;
		write_mode(pbc_pkg::BM_NORMAL);
		send_pixel('0);
		send_pixel('1);
		send_pixel('{8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255});
		send_pixel('{8'd255, 8'd0, 8'd128, 8'd255, 8'd128, 8'd255, 8'd127, 8'd0});
		for (int i = 1; i < 16; i++) begin
			m = 4'(i);
			write_mode(m);
			send_pixel('{8'd200, 8'd30, 8'd128, 8'd255, 8'd180, 8'd255, 8'd0, 8'd129});
		end
		write_mode(pbc_pkg::BM_SOFT);
		send_pixel('{8'd255, 8'd40, 8'd64, 8'd200, 8'd255, 8'd200, 8'd255, 8'd128});
		write_mode(pbc_pkg::BM_BURN);
		send_pixel('{8'd255, 8'd255, 8'd0, 8'd100, 8'd255, 8'd0, 8'd0, 8'd1});
		write_mode(pbc_pkg::BM_DODGE);
		send_pixel('{8'd255, 8'd0, 8'd200, 8'd100, 8'd255, 8'd255, 8'd254, 8'd0});
	endtask

	task automatic test_random;
		int ph;
		for (int n = 0; n < 1250; n++) begin
			ph = n / 313;
			src_idle = (ph == 1) ? 75 : (ph == 3) ? 36 : 0;
			sink_stall = (ph == 2) ? 75 : (ph == 3) ? 36 : 0;
			if (n % 40 == 0) write_mode(4'($urandom_range(15)));
			if (n % 40 == 20 && $urandom_range(9) < 3) begin
				src_idle = 0;
				sink_stall = 0;
			end
			if (n == 600) drain();
			send_pixel(random_pair());
		end
	endtask

	task automatic test_mode_extremes;
		write_mode(4'd15);
		for (int n = 0; n < 20; n++) send_pixel(random_pair());
		write_mode(pbc_pkg::BM_REMOVE);
		for (int n = 0; n < 20; n++) send_pixel(random_pair());
		write_mode(pbc_pkg::BM_NORMAL);
		for (int n = 0; n < 20; n++) send_pixel(random_pair());
	endtask

	initial begin
		pix_in.valid = 1'b0;
		pix_in.dst_alpha = '0;
		pix_in.dst_red = '0;
		pix_in.dst_green = '0;
		pix_in.dst_blue = '0;
		pix_in.src_alpha = '0;
		pix_in.src_red = '0;
		pix_in.src_green = '0;
		pix_in.src_blue = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_mode_extremes();
		drain();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
